// ----- sv/ais_pkg.sv -----
package ais_pkg;
	localparam int unsigned AddrW = 24;
	localparam int unsigned EndW = 25;
	localparam int unsigned CountW = 17;
	localparam logic [CountW-1:0] BankSize = 17'h10000;

	localparam logic OpClaim = 1'b0;
	localparam logic OpContains = 1'b1;

	typedef struct packed {
		logic op;
		logic [AddrW-1:0] address;
		logic [CountW-1:0] byte_count;
	} req_t;

	typedef struct packed {
		logic ok;
		logic table_full;
	} rsp_t;

	// One table entry: start and end of a half-open interval.
	typedef struct packed {
		logic [AddrW-1:0] start;
		logic [EndW-1:0] stop;
	} entry_t;

	localparam int unsigned EntryW = AddrW + EndW;
endpackage

// ----- sv/ais_stream_if.sv -----
interface ais_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/ais_ram.sv -----
module ais_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/ais_seq.sv -----
module ais_seq #(
	parameter int unsigned MaxIntervals = 64
) (
	input logic clk,
	input logic arst_n,
	ais_stream_if.sink req,
	ais_stream_if.source rsp
);
	localparam int unsigned IdxW = $clog2(MaxIntervals);
	localparam int unsigned CntW = $clog2(MaxIntervals + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(MaxIntervals);

	typedef enum logic [10:0] {
		StIdle    = 11'b00000000001,
		StPiece   = 11'b00000000010,
		StScanRd  = 11'b00000000100,
		StScan    = 11'b00000001000,
		StDecide  = 11'b00000010000,
		StShiftRd = 11'b00000100000,
		StShift   = 11'b00001000000,
		StMergeRd = 11'b00010000000,
		StMerge   = 11'b00100000000,
		StPackRd  = 11'b01000000000,
		StPack    = 11'b10000000000
	} state_t;

	state_t state_q;
	logic op_q;
	logic [ais_pkg::AddrW-1:0] addr_q;
	logic [ais_pkg::CountW-1:0] len_q;
	logic [ais_pkg::AddrW-1:0] ps_q;
	logic [ais_pkg::EndW-1:0] pe_q;
	logic [CntW-1:0] n_q;
	logic [CntW-1:0] p_q;
	logic [CntW-1:0] i_q;
	logic [CntW-1:0] k_q;
	logic [CntW-1:0] m_q;
	logic have_prev_q;
	ais_pkg::entry_t prev_q;
	ais_pkg::entry_t ek_q;
	logic ok_q;
	logic full_q;
	logic out_valid_q;
	ais_pkg::rsp_t out_q;

	logic we;
	logic [IdxW-1:0] waddr;
	logic [IdxW-1:0] raddr;
	ais_pkg::entry_t wdata;
	ais_pkg::entry_t rdata;
	logic [ais_pkg::EntryW-1:0] rdata_raw;

	ais_ram #(.Width(ais_pkg::EntryW), .Depth(MaxIntervals)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata_raw)
	);
	assign rdata = ais_pkg::entry_t'(rdata_raw);

	// Piece sizing: the room left in the bank.
	logic [ais_pkg::CountW-1:0] room;
	logic [ais_pkg::CountW-1:0] piece;
	assign room = ais_pkg::BankSize - {1'b0, addr_q[15:0]};
	assign piece = (len_q < room) ? len_q : room;

	// The shared compare unit: entry start against the scan key.
	logic [ais_pkg::EndW-1:0] key;
	logic start_le_key;
	assign key = op_q ? {1'b0, addr_q} : {1'b0, ps_q};
	assign start_le_key = {1'b0, rdata.start} <= key;

	assign req.ready = (state_q == StIdle) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	// Read address follows the walk: shift reads one below, merge reads m.
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = rdata;
		raddr = i_q[IdxW-1:0];
		case (state_q)
			StShiftRd: begin
				raddr = IdxW'(i_q - CntW'(1));
			end
			StShift: begin
				we = 1'b1;
				waddr = IdxW'(i_q);
				if (i_q == p_q) begin
					wdata.start = ps_q;
					wdata.stop = pe_q;
				end
			end
			StMergeRd: begin
				raddr = IdxW'(m_q);
			end
			StMerge: begin
				we = 1'b1;
				waddr = IdxW'(k_q);
				wdata = ek_q;
			end
			StPack: begin
				we = 1'b1;
				waddr = IdxW'(i_q - (m_q - k_q - CntW'(1)));
			end
			default: begin
			end
		endcase
	end

	logic [ais_pkg::EndW-1:0] e_new;
	assign e_new = (prev_q.stop > pe_q) ? prev_q.stop : pe_q;

	// Sequencer: scan, then (for a claim) insert, merge or collapse, one entry at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (req.valid && req.ready) begin
						op_q <= req.data.op;
						addr_q <= req.data.address;
						len_q <= (req.data.byte_count > ais_pkg::BankSize)
							? ais_pkg::BankSize : req.data.byte_count;
						ok_q <= 1'b1;
						full_q <= 1'b0;
						if (req.data.op == ais_pkg::OpContains) begin
							i_q <= '0;
							have_prev_q <= 1'b0;
							state_q <= StScanRd;
						end else begin
							state_q <= StPiece;
						end
					end
				end
				StPiece: begin
					if (len_q == '0) begin
						out_q <= '{ok: ok_q, table_full: full_q};
						out_valid_q <= 1'b1;
						state_q <= StIdle;
					end else begin
						ps_q <= addr_q;
						pe_q <= {1'b0, addr_q} + ais_pkg::EndW'(piece);
						len_q <= len_q - piece;
						addr_q <= {addr_q[23:16], 16'h0};
						i_q <= '0;
						have_prev_q <= 1'b0;
						state_q <= StScanRd;
					end
				end
				StScanRd: begin
					if (i_q >= n_q) begin
						p_q <= i_q;
						if (op_q == ais_pkg::OpContains) begin
							out_q <= '{ok: have_prev_q && ({1'b0, addr_q} < prev_q.stop),
								table_full: 1'b0};
							out_valid_q <= 1'b1;
							state_q <= StIdle;
						end else begin
							state_q <= StDecide;
						end
					end else begin
						state_q <= StScan;
					end
				end
				StScan: begin
					if (start_le_key) begin
						prev_q <= rdata;
						have_prev_q <= 1'b1;
						i_q <= i_q + CntW'(1);
						state_q <= StScanRd;
					end else begin
						p_q <= i_q;
						ek_q <= rdata;
						if (op_q == ais_pkg::OpContains) begin
							out_q <= '{ok: have_prev_q && ({1'b0, addr_q} < prev_q.stop),
								table_full: 1'b0};
							out_valid_q <= 1'b1;
							state_q <= StIdle;
						end else begin
							state_q <= StDecide;
						end
					end
				end
				// Decide on the piece against its neighbors.
				StDecide: begin
					if (have_prev_q && {1'b0, ps_q} <= prev_q.stop) begin
						k_q <= p_q - CntW'(1);
						if ({1'b0, ps_q} < prev_q.stop) begin
							ok_q <= 1'b0;
						end
						ek_q.start <= prev_q.start;
						ek_q.stop <= e_new;
						m_q <= p_q;
						i_q <= p_q;
						state_q <= StMergeRd;
					end else if (p_q < n_q && {1'b0, ek_q.start} <= pe_q) begin
						k_q <= p_q;
						if ({1'b0, ek_q.start} < pe_q) begin
							ok_q <= 1'b0;
						end
						ek_q.start <= ps_q;
						ek_q.stop <= (ek_q.stop > pe_q) ? ek_q.stop : pe_q;
						m_q <= p_q + CntW'(1);
						i_q <= p_q + CntW'(1);
						state_q <= StMergeRd;
					end else if (n_q >= CntMax) begin
						full_q <= 1'b1;
						state_q <= StPiece;
					end else begin
						i_q <= n_q;
						state_q <= StShiftRd;
					end
				end
				StShiftRd: begin
					state_q <= StShift;
				end
				StShift: begin
					if (i_q == p_q) begin
						n_q <= n_q + CntW'(1);
						state_q <= StPiece;
					end else begin
						i_q <= i_q - CntW'(1);
						state_q <= StShiftRd;
					end
				end
				StMergeRd: begin
					state_q <= StMerge;
				end
				StMerge: begin
					if (m_q < n_q && {1'b0, rdata.start} <= ek_q.stop) begin
						if (m_q == k_q + CntW'(1) && ek_q.stop > {1'b0, rdata.start}) begin
							ok_q <= 1'b0;
						end
						if (rdata.stop > ek_q.stop) begin
							ek_q.stop <= rdata.stop;
						end
						m_q <= m_q + CntW'(1);
						state_q <= StMergeRd;
					end else if (m_q > k_q + CntW'(1)) begin
						i_q <= m_q;
						state_q <= StPackRd;
					end else begin
						state_q <= StPiece;
					end
				end
				StPackRd: begin
					if (i_q >= n_q) begin
						n_q <= n_q - (m_q - k_q - CntW'(1));
						state_q <= StPiece;
					end else begin
						state_q <= StPack;
					end
				end
				StPack: begin
					i_q <= i_q + CntW'(1);
					state_q <= StPackRd;
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end
endmodule

// ----- sv/address_interval_set_core.sv -----
// Channel | Direction | Payload
// req     | in        | op, address, byte_count
// rsp     | out       | ok, table_full
// A contains scans the stored intervals. For a claim piece, one RAM read port
// walks the table entry by entry, first for the scan and then for the insert
// shift or the collapse.
// A claim split at the bank end does this twice.
// The block takes no request until the previous response is taken.
// Reset clears the count, state and response valid; table entries are written before use.
module address_interval_set_core #(
	parameter int unsigned MAX_INTERVALS = 64
) (
	input logic clk,
	input logic arst_n,
	ais_stream_if.sink req,
	ais_stream_if.source rsp
);
	ais_seq #(.MaxIntervals(MAX_INTERVALS)) u_seq (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);
endmodule

// ----- sv/ais_checker.sv -----
module ais_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready
);
	// No new request while a response waits.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("request taken while busy");
	// Accepting a request takes the block busy.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
	// A held response stays until taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
endmodule

bind address_interval_set_core ais_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);
